// File: hw/rtl/atf_pkg.sv
// ----------------------------------------------------------------------------
// atf_pkg: shared types and constants for the accelerometer tilt filter
// Widths of the CORDIC datapath, angle limits and the arctangent table.
// ----------------------------------------------------------------------------
package atf_pkg;

	// Width of the CORDIC input operands (a Q16.16 value or its negation).
	localparam int CIN_W = 33;
	// Width of the CORDIC x and y registers, with headroom for the gain.
	localparam int XY_W = 36;
	// Width of the Q4.30 angle accumulator.
	localparam int ANG_W = 34;
	// Width of the angle result port of the CORDIC unit.
	localparam int OUT_ANG_W = 16;

	localparam int HALF_PI_Q30 = 1686629713;
	localparam int ROLL_LIMIT = 25736;
	localparam int PITCH_LIMIT = 12868;
	// Half an output LSB in the Q4.30 accumulator (Q3.13 output).
	localparam int ROUND_Q17 = 65536;
	localparam int ROUND_SHIFT = 17;

	typedef struct packed {
		logic start;
		logic pitch_sel;
	} atf_cordic_ctl_t;

	function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] idx);
		logic signed [ANG_W-1:0] v;
		case (idx)
			5'd0: v = ANG_W'(843314857);
			5'd1: v = ANG_W'(497837829);
			5'd2: v = ANG_W'(263043837);
			5'd3: v = ANG_W'(133525159);
			5'd4: v = ANG_W'(67021687);
			5'd5: v = ANG_W'(33543516);
			5'd6: v = ANG_W'(16775851);
			5'd7: v = ANG_W'(8388437);
			5'd8: v = ANG_W'(4194283);
			5'd9: v = ANG_W'(2097149);
			5'd10: v = ANG_W'(1048576);
			5'd11: v = ANG_W'(524288);
			5'd12: v = ANG_W'(262144);
			5'd13: v = ANG_W'(131072);
			5'd14: v = ANG_W'(65536);
			5'd15: v = ANG_W'(32768);
			5'd16: v = ANG_W'(16384);
			5'd17: v = ANG_W'(8192);
			5'd18: v = ANG_W'(4096);
			5'd19: v = ANG_W'(2048);
			5'd20: v = ANG_W'(1024);
			5'd21: v = ANG_W'(512);
			5'd22: v = ANG_W'(256);
			5'd23: v = ANG_W'(128);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: hw/rtl/atf_cordic.sv
// ----------------------------------------------------------------------------
// atf_cordic: iterative CORDIC vectoring unit
// Computes atan2(num, den) one micro-rotation per cycle and returns the angle
// rounded to Q3.13 and clamped to the roll or pitch limit.
// ----------------------------------------------------------------------------
module atf_cordic
	import atf_pkg::*;
#(
	parameter int STEPS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  atf_cordic_ctl_t             ctl,
	input  logic signed [CIN_W-1:0]     num,
	input  logic signed [CIN_W-1:0]     den,
	output logic                        done,
	output logic signed [OUT_ANG_W-1:0] angle
);

	localparam int CNT_W = $clog2(STEPS);

	logic                    run_q;
	logic                    done_q;
	logic                    zero_q;
	logic                    sel_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [XY_W-1:0]  x_q, y_q;
	logic signed [ANG_W-1:0] z_q;

	logic signed [XY_W-1:0]  x_init, y_init, xe, ye;
	logic signed [ANG_W-1:0] z_init;
	logic signed [XY_W-1:0]  xs, ys, x_nxt, y_nxt;
	logic signed [ANG_W-1:0] z_nxt, at;
	logic                    last;
	logic signed [ANG_W:0]   rnd, rsh, lim, clamp;

	// A vector in the left half plane is turned by a quarter turn first.
	always_comb begin
		xe = XY_W'(den);
		ye = XY_W'(num);
		if (den[CIN_W-1]) begin
			if (!num[CIN_W-1]) begin
				x_init = ye;
				y_init = -xe;
				z_init = ANG_W'(HALF_PI_Q30);
			end else begin
				x_init = -ye;
				y_init = xe;
				z_init = -ANG_W'(HALF_PI_Q30);
			end
		end else begin
			x_init = xe;
			y_init = ye;
			z_init = '0;
		end
	end

	always_comb begin
		xs = x_q >>> cnt_q;
		ys = y_q >>> cnt_q;
		at = atan_entry(5'(cnt_q));
		if (y_q[XY_W-1]) begin
			x_nxt = x_q - ys;
			y_nxt = y_q + xs;
			z_nxt = z_q - at;
		end else begin
			x_nxt = x_q + ys;
			y_nxt = y_q - xs;
			z_nxt = z_q + at;
		end
	end

	assign last = (cnt_q == CNT_W'(STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			zero_q <= 1'b0;
			sel_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				run_q  <= 1'b1;
				cnt_q  <= '0;
				sel_q  <= ctl.pitch_sel;
				zero_q <= (num == '0) && (den == '0);
			end else if (run_q) begin
				if (last) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q <= x_init;
			y_q <= y_init;
			z_q <= z_init;
		end else if (run_q) begin
			x_q <= x_nxt;
			y_q <= y_nxt;
			z_q <= z_nxt;
		end
	end

	always_comb begin
		rnd = (ANG_W+1)'(z_q) + (ANG_W+1)'(ROUND_Q17);
		rsh = rnd >>> ROUND_SHIFT;
		lim = sel_q ? (ANG_W+1)'(PITCH_LIMIT) : (ANG_W+1)'(ROLL_LIMIT);
		if (rsh > lim) begin
			clamp = lim;
		end else if (rsh < -lim) begin
			clamp = -lim;
		end else begin
			clamp = rsh;
		end
	end

	// The zero vector has no direction and reads as angle zero.
	assign angle = zero_q ? '0 : OUT_ANG_W'(clamp);
	assign done  = done_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !run_q)
		else $error("CORDIC done raised while still iterating");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> (!run_q && !done_q))
		else $error("CORDIC started while busy");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q && !ctl.start && !last) |=> (run_q && cnt_q == $past(cnt_q) + 1'b1))
		else $error("CORDIC iteration count skipped");

endmodule

// File: hw/rtl/atf_isqrt.sv
// ----------------------------------------------------------------------------
// atf_isqrt: iterative 64-bit integer square root
// Digit-by-digit restoring square root, one result bit per cycle, floored.
// ----------------------------------------------------------------------------
module atf_isqrt
	import atf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] operand,
	output logic        done,
	output logic [31:0] root
);

	localparam int ISQ_STEPS = 32;
	localparam logic [5:0] TOP_SHIFT = 6'd62;

	logic        run_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] res_q;

	logic [63:0] bitv;
	logic [64:0] trial;
	logic        take;
	logic        last;

	always_comb begin
		bitv  = 64'd1 << (TOP_SHIFT - {cnt_q, 1'b0});
		trial = {1'b0, res_q} + {1'b0, bitv};
		take  = ({1'b0, rem_q} >= trial);
	end

	assign last = (cnt_q == 5'(ISQ_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (last) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= operand;
			res_q <= '0;
		end else if (run_q) begin
			if (take) begin
				rem_q <= rem_q - trial[63:0];
				res_q <= (res_q >> 1) + bitv;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];

endmodule

// File: hw/rtl/accel_tilt_filter.sv
// ----------------------------------------------------------------------------
// accel_tilt_filter: low-pass filtered three-axis tilt sensor
// Each input beat passes through the filter update of the three axes, two
// CORDIC runs of one rotation per cycle and a square root, all sequential.
// The input stalls while a sample is in work. Reset clears the three filter states.
// ----------------------------------------------------------------------------
module accel_tilt_filter
	import atf_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] accel_x,
	input  logic signed [SAMPLE_WIDTH-1:0] accel_y,
	input  logic signed [SAMPLE_WIDTH-1:0] accel_z,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [15:0]            roll_angle,
	output logic signed [14:0]            pitch_angle,
	output logic signed [15:0]            filtered_z_out
);

	localparam logic [3:0] ST_IDLE       = 4'd0;
	localparam logic [3:0] ST_FILT       = 4'd1;
	localparam logic [3:0] ST_ROLL_GO    = 4'd2;
	localparam logic [3:0] ST_ROLL_WAIT  = 4'd3;
	localparam logic [3:0] ST_SQ_Y       = 4'd4;
	localparam logic [3:0] ST_SQ_Z       = 4'd5;
	localparam logic [3:0] ST_SQRT_GO    = 4'd6;
	localparam logic [3:0] ST_SQRT_WAIT  = 4'd7;
	localparam logic [3:0] ST_PITCH_GO   = 4'd8;
	localparam logic [3:0] ST_PITCH_WAIT = 4'd9;
	localparam logic [3:0] ST_OUT        = 4'd10;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	// Filter datapath widths: d = s*2^16 - f, acc = f*2^16 + d*655 + 2^15.
	localparam int DW = ((SAMPLE_WIDTH + 16 > 32) ? SAMPLE_WIDTH + 16 : 32) + 1;
	localparam int PW = DW + 11;
	localparam int AW = DW + 17;
	localparam int COEF_NEW = 655;
	localparam int ROUND_HALF = 32768;
	localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

	logic [3:0]                    state_q;
	logic [1:0]                    axis_q;
	logic signed [SAMPLE_WIDTH-1:0] samp_q [3];
	logic signed [31:0]            filt_q [3];
	logic [63:0]                   sq_prod_q;
	logic [63:0]                   sq_sum_q;
	logic signed [15:0]            roll_q;
	logic signed [14:0]            pitch_q;
	logic                          out_valid_q;
	logic signed [15:0]            roll_out_q;
	logic signed [14:0]            pitch_out_q;
	logic signed [15:0]            fz_out_q;

	logic signed [31:0]            filt_sel;
	logic signed [SAMPLE_WIDTH-1:0] samp_sel;
	logic signed [DW-1:0]          flt_d;
	logic signed [PW-1:0]          flt_p;
	logic signed [AW-1:0]          flt_acc, flt_sh;
	logic signed [31:0]            flt_new;

	logic signed [31:0]            sq_src;
	logic [31:0]                   sq_a;
	logic [63:0]                   sq_prod;

	atf_cordic_ctl_t               cor_ctl;
	logic signed [CIN_W-1:0]       cor_num, cor_den;
	logic                          cor_done;
	logic signed [OUT_ANG_W-1:0]   cor_angle;
	logic                          sqrt_start;
	logic                          sqrt_done;
	logic [31:0]                   sqrt_root;

	logic                          in_take;
	logic                          out_load;

	// ---- first-order low-pass, one axis per cycle through one multiplier ----
	always_comb begin
		filt_sel = filt_q[axis_q];
		samp_sel = samp_q[axis_q];
		flt_d    = (DW'(samp_sel) <<< 16) - DW'(filt_sel);
		flt_p    = PW'(flt_d) * PW'(COEF_NEW);
		flt_acc  = AW'(flt_p) + (AW'(filt_sel) <<< 16) + AW'(ROUND_HALF);
		flt_sh   = flt_acc >>> 16;
		if ((&flt_sh[AW-1:31]) || !(|flt_sh[AW-1:31])) begin
			flt_new = flt_sh[31:0];
		end else if (flt_sh[AW-1]) begin
			flt_new = SAT_MIN;
		end else begin
			flt_new = SAT_MAX;
		end
	end

	// ---- squares of the filtered y and z magnitudes ----
	always_comb begin
		sq_src  = (state_q == ST_SQ_Z) ? filt_q[AXIS_Z] : filt_q[AXIS_Y];
		sq_a    = sq_src[31] ? 32'(-sq_src) : 32'(sq_src);
		sq_prod = 64'(sq_a) * 64'(sq_a);
	end

	// ---- shared CORDIC unit: roll first, then pitch ----
	always_comb begin
		cor_ctl.start     = (state_q == ST_ROLL_GO) || (state_q == ST_PITCH_GO);
		cor_ctl.pitch_sel = (state_q == ST_PITCH_GO);
		if (state_q == ST_PITCH_GO) begin
			cor_num = -CIN_W'(filt_q[AXIS_X]);
			cor_den = $signed({1'b0, sqrt_root});
		end else begin
			cor_num = CIN_W'(filt_q[AXIS_Y]);
			cor_den = CIN_W'(filt_q[AXIS_Z]);
		end
	end

	assign sqrt_start = (state_q == ST_SQRT_GO);

	atf_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (cor_ctl),
		.num   (cor_num),
		.den   (cor_den),
		.done  (cor_done),
		.angle (cor_angle)
	);

	atf_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.operand(sq_sum_q + sq_prod_q),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= AXIS_X;
			out_valid_q <= 1'b0;
			filt_q[0]   <= '0;
			filt_q[1]   <= '0;
			filt_q[2]   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						axis_q  <= AXIS_X;
						state_q <= ST_FILT;
					end
				end
				ST_FILT: begin
					filt_q[axis_q] <= flt_new;
					if (axis_q == AXIS_Z) begin
						state_q <= ST_ROLL_GO;
					end else begin
						axis_q <= axis_q + 1'b1;
					end
				end
				ST_ROLL_GO: state_q <= ST_ROLL_WAIT;
				ST_ROLL_WAIT: begin
					if (cor_done) begin
						state_q <= ST_SQ_Y;
					end
				end
				ST_SQ_Y: state_q <= ST_SQ_Z;
				ST_SQ_Z: state_q <= ST_SQRT_GO;
				ST_SQRT_GO: state_q <= ST_SQRT_WAIT;
				ST_SQRT_WAIT: begin
					if (sqrt_done) begin
						state_q <= ST_PITCH_GO;
					end
				end
				ST_PITCH_GO: state_q <= ST_PITCH_WAIT;
				ST_PITCH_WAIT: begin
					if (cor_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// A finished beat may wait here while the next sample is taken in.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---- payload registers ----
	always_ff @(posedge clk) begin
		if (in_take) begin
			samp_q[AXIS_X] <= accel_x;
			samp_q[AXIS_Y] <= accel_y;
			samp_q[AXIS_Z] <= accel_z;
		end
		if (state_q == ST_SQ_Y) begin
			sq_prod_q <= sq_prod;
		end
		if (state_q == ST_SQ_Z) begin
			sq_sum_q  <= sq_prod_q;
			sq_prod_q <= sq_prod;
		end
		if ((state_q == ST_ROLL_WAIT) && cor_done) begin
			roll_q <= cor_angle;
		end
		if ((state_q == ST_PITCH_WAIT) && cor_done) begin
			pitch_q <= cor_angle[14:0];
		end
		if (out_load) begin
			roll_out_q  <= roll_q;
			pitch_out_q <= pitch_q;
			fz_out_q    <= filt_q[AXIS_Z][31:16];
		end
	end

	assign out_valid      = out_valid_q;
	assign roll_angle     = roll_out_q;
	assign pitch_angle    = pitch_out_q;
	assign filtered_z_out = fz_out_q;

	a_take_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (state_q == ST_FILT))
		else $error("accepted sample did not start the filter");

	a_cordic_done: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> (state_q == ST_ROLL_WAIT || state_q == ST_PITCH_WAIT))
		else $error("CORDIC finished outside a wait state");

	a_sqrt_done: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> (state_q == ST_SQRT_WAIT))
		else $error("square root finished outside its wait state");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_valid_q && out_stall) |=> (state_q == ST_OUT))
		else $error("result overwrote a stalled output beat");

endmodule

// File: test/tb_accel_tilt_filter.sv
// ----------------------------------------------------------------------------
// tb_accel_tilt_filter: self-checking bench for the accelerometer tilt filter
// Drives raw three-axis samples through the valid/stall input and checks every
// result beat against a bit-exact model of the low-pass filters, the
// square root and the two CORDIC arctangents. Traffic runs in phases with
// and without random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_accel_tilt_filter;
	import atf_pkg::*;

	localparam int STEPS = 16;
	localparam int PHASE_ITEMS = 100;
	localparam int KEEP_WEIGHT = 64881;
	localparam int NEW_WEIGHT = 655;

	typedef struct {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic signed [15:0] z_int;
	} tilt_result_t;

	class tilt_checker;
		logic signed [31:0] lp_x, lp_y, lp_z;
		tilt_result_t pending_tilt[$];
		int errors;
		longint atan_tab[24] = '{
			843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
			16775851, 8388437, 4194283, 2097149, 1048576, 524288,
			262144, 131072, 65536, 32768, 16384, 8192,
			4096, 2048, 1024, 512, 256, 128};

		function new();
			lp_x = '0;
			lp_y = '0;
			lp_z = '0;
			errors = 0;
		endfunction

		function int pending();
			return pending_tilt.size();
		endfunction

		task report(string msg);
			if (errors < 50)
				$display("MISMATCH @%0t: %s", $realtime, msg);
			errors++;
		endtask

		function logic signed [31:0] lowpass(logic signed [31:0] f, logic signed [15:0] s);
			longint acc;
			acc = longint'(f) * KEEP_WEIGHT + longint'(s) * 65536 * NEW_WEIGHT + 32768;
			acc = acc >>> 16;
			if (acc > 64'sd2147483647)
				acc = 64'sd2147483647;
			if (acc < -64'sd2147483648)
				acc = -64'sd2147483648;
			return acc[31:0];
		endfunction

		// Floor of the square root, built one result bit at a time.
		function longint unsigned root64(longint unsigned n);
			longint unsigned res, trial;
			res = 0;
			for (int b = 31; b >= 0; b--) begin
				trial = res | (64'd1 << b);
				if (trial * trial <= n)
					res = trial;
			end
			return res;
		endfunction

		function longint arctan_q13(longint num, longint den, longint limit);
			longint xr, yr, acc, t, xs, ys, r;
			if (num == 0 && den == 0)
				return 0;
			xr = den;
			yr = num;
			acc = 0;
			// Left half plane: turn by a quarter first so the iterations converge.
			if (xr < 0) begin
				if (yr >= 0) begin
					t = xr; xr = yr; yr = -t; acc = HALF_PI_Q30;
				end else begin
					t = xr; xr = -yr; yr = t; acc = -HALF_PI_Q30;
				end
			end
			for (int i = 0; i < STEPS; i++) begin
				xs = xr >>> i;
				ys = yr >>> i;
				if (yr >= 0) begin
					xr = xr + ys; yr = yr - xs; acc = acc + atan_tab[i];
				end else begin
					xr = xr - ys; yr = yr + xs; acc = acc - atan_tab[i];
				end
			end
			r = (acc + ROUND_Q17) >>> ROUND_SHIFT;
			if (r > limit)
				r = limit;
			if (r < -limit)
				r = -limit;
			return r;
		endfunction

		function void note_sample(logic signed [15:0] sx, logic signed [15:0] sy,
				logic signed [15:0] sz);
			tilt_result_t e;
			longint unsigned ay, az, mag;
			longint zi;
			lp_x = lowpass(lp_x, sx);
			lp_y = lowpass(lp_y, sy);
			lp_z = lowpass(lp_z, sz);
			e.roll = 16'(arctan_q13(longint'(lp_y), longint'(lp_z), ROLL_LIMIT));
			ay = (lp_y < 0) ? longint'(-longint'(lp_y)) : longint'(lp_y);
			az = (lp_z < 0) ? longint'(-longint'(lp_z)) : longint'(lp_z);
			mag = root64(ay * ay + az * az);
			e.pitch = 15'(arctan_q13(-longint'(lp_x), longint'(mag), PITCH_LIMIT));
			zi = longint'(lp_z) >>> 16;
			if (zi > 32767)
				zi = 32767;
			if (zi < -32768)
				zi = -32768;
			e.z_int = 16'(zi);
			pending_tilt.push_back(e);
		endfunction

		task check_result(logic signed [15:0] roll, logic signed [14:0] pitch,
				logic signed [15:0] z_int);
			tilt_result_t e;
			if (pending_tilt.size() == 0) begin
				report($sformatf("unexpected result roll=%0d pitch=%0d z=%0d",
					roll, pitch, z_int));
				return;
			end
			e = pending_tilt.pop_front();
			if (roll !== e.roll || pitch !== e.pitch || z_int !== e.z_int)
				report($sformatf("roll %0d/%0d pitch %0d/%0d z %0d/%0d (got/exp)",
					roll, e.roll, pitch, e.pitch, z_int, e.z_int));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [15:0] accel_x, accel_y, accel_z;
	logic out_valid;
	logic out_stall;
	logic signed [15:0] roll_angle;
	logic signed [14:0] pitch_angle;
	logic signed [15:0] filtered_z_out;

	tilt_checker board = new();
	int send_idle_pct;
	int stall_pct;

	accel_tilt_filter dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.accel_x        (accel_x),
		.accel_y        (accel_y),
		.accel_z        (accel_z),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.roll_angle     (roll_angle),
		.pitch_angle    (pitch_angle),
		.filtered_z_out (filtered_z_out)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(roll_angle, pitch_angle, filtered_z_out);
	end

	function automatic logic signed [15:0] clamp16(int v);
		if (v > 32767)
			return 16'sd32767;
		if (v < -32768)
			return -16'sd32768;
		return 16'(v);
	endfunction

	function automatic logic signed [15:0] pick_extreme();
		case ($urandom_range(3))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sh0000;
			default: return 16'shffff;
		endcase
	endfunction

	// Valid stays high across back-to-back beats; it drops only in a gap or while the bench drains.
	task automatic send_sample(logic signed [15:0] sx, logic signed [15:0] sy,
			logic signed [15:0] sz);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		accel_x <= sx;
		accel_y <= sy;
		accel_z <= sz;
		do
			@(posedge clk);
		while (in_stall);
		board.note_sample(sx, sy, sz);
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		logic signed [15:0] bx, by, bz;
		int sent, run_len, mode, noise;

		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		accel_x = '0;
		accel_y = '0;
		accel_z = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero vector first: both angles must come out as zero.
		send_sample(16'sd0, 16'sd0, 16'sd0);
		// y stays exactly zero with z negative, so roll lands on plus pi.
		repeat (3)
			send_sample(16'sd0, 16'sd0, -16'sd32768);
		send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_sample(16'sh8000, 16'sh8000, 16'sh8000);
		send_sample(16'sh7fff, 16'sh8000, 16'sh0000);
		send_sample(16'sh8000, 16'sh7fff, 16'shffff);
		send_sample(-16'sd1, -16'sd1, -16'sd1);
		repeat (4)
			send_sample(16'sh8000, 16'sh8000, 16'sh8000);
		repeat (4)
			send_sample(16'sh7fff, 16'sh8000, 16'sh7fff);
		repeat (4)
			send_sample(16'sh0000, 16'sh7fff, 16'sh8000);
		hold_until_drained();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 64; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 64; end
				default: begin send_idle_pct = 27; stall_pct = 27; end
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				mode = $urandom_range(9);
				bx = 16'($urandom);
				by = 16'($urandom);
				bz = 16'($urandom);
				if (mode <= 5) begin
					// Steady orientation with a little noise, so the filter settles.
					run_len = $urandom_range(40, 8);
					noise = 1 << $urandom_range(11);
					repeat (run_len)
						send_sample(
							clamp16(int'(bx) + $urandom_range(2 * noise) - noise),
							clamp16(int'(by) + $urandom_range(2 * noise) - noise),
							clamp16(int'(bz) + $urandom_range(2 * noise) - noise));
				end else if (mode <= 7) begin
					run_len = $urandom_range(10, 1);
					repeat (run_len)
						send_sample(16'($urandom), 16'($urandom), 16'($urandom));
				end else if (mode == 8) begin
					run_len = $urandom_range(30, 5);
					bx = pick_extreme();
					by = pick_extreme();
					bz = pick_extreme();
					repeat (run_len)
						send_sample(bx, by, bz);
				end else begin
					// One or two axes held at zero pull the vector onto an axis.
					run_len = $urandom_range(30, 10);
					if ($urandom_range(1))
						bx = '0;
					by = '0;
					repeat (run_len)
						send_sample(bx, by, bz);
				end
				sent += run_len;
			end
			hold_until_drained();
		end

		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (board.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#6000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
